// ----- rtl/sbm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_pkg
// shared types, codes and constants of the serial bank mapper
// ----------------------------------------------------------------------------
package sbm_pkg;

    // request codes
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_INIT    = 2'd1;
    localparam logic [1:0] REQ_RESTORE = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_PRG = 2'd0;
    localparam logic [1:0] KIND_CHR = 2'd1;
    localparam logic [1:0] KIND_MIR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PRG_IDX = 2'd0;
    localparam logic [1:0] CFG_CHR_IDX = 2'd1;

    // mapper register indexes
    localparam logic [1:0] REG_CTRL = 2'd0;
    localparam logic [1:0] REG_CHR0 = 2'd1;
    localparam logic [1:0] REG_CHR1 = 2'd2;
    localparam logic [1:0] REG_PRG  = 2'd3;

    localparam logic [6:0] PRG_CFG_RESET = 7'd2;
    localparam logic [5:0] CHR_CFG_RESET = 6'd0;
    localparam logic [4:0] CTRL_RESET    = 5'h0c;
    localparam logic [6:0] PRG_1024K     = 7'd64;
    localparam logic [6:0] PRG_512K      = 7'd32;
    localparam logic [6:0] LARGE_HI0     = 7'd30;
    localparam logic [6:0] LARGE_HI1     = 7'd31;
    localparam logic [2:0] SHIFT_BITS    = 3'd5;
    localparam logic [2:0] DIV_STEPS     = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_MIR,
        PH_PRG,
        PH_CHR
    } phase_t;

    typedef struct packed {
        logic       start;
        logic [6:0] dividend;
        logic [8:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic       busy;
        logic [6:0] remainder;
    } rem_rsp_t;

    typedef struct packed {
        logic       push;
        logic [1:0] kind;
        logic [2:0] slot;
        logic [7:0] page;
        logic       ram;
        logic [1:0] mir;
        logic       last;
    } out_push_t;

endpackage
`default_nettype wire

// ----- rtl/serial_bank_mapper_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_bank_mapper_unit
// serial-write bank-switching mapper producing slot remap items
// ----------------------------------------------------------------------------
// usage
//   s_axis carries requests: bus writes, init and restore. m_axis carries
//   remap items, one per changed slot, tlast on the final one of a request.
//   cfg writes set program and character sizes; cfg_ready is tied high.
// timing
//   a write that only shifts leaves the block idle. each program or character
//   rom page needs a 7-step remainder in the shared remainder unit; mirroring
//   and character ram items need none. s_axis_tready is low until the last
//   item of a request is loaded into the output register. cfg writes are to
//   be made only while idle; the block itself does not enforce this.
// reset
//   sizes return to 2 x 16K program, character ram; mapper state as at init.
//   the first program slots after reset read banks 0..3.
// stalls
//   the output register holds its item while m_axis_tready is low and the
//   sequencer waits with the next one; nothing is dropped.
// ----------------------------------------------------------------------------
module serial_bank_mapper_unit
    import sbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // bus_address[15:0], bus_data[23:16]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // slot_index[2:0], page_number[10:3],
                                        // chr_is_ram[11], mirror_mode[13:12]
    output logic [1:0]  m_axis_tuser,   // target_kind[1:0]
    output logic        m_axis_tlast,   // last_result
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    logic [6:0]  prg_cfg_reg;
    logic [5:0]  chr_cfg_reg;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic [1:0]  out_kind_reg;
    logic        out_last_reg;
    logic        out_free;
    out_push_t   push;
    rem_req_t    rem_req;
    rem_rsp_t    rem_rsp;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_cfg_reg   <= PRG_CFG_RESET;
            chr_cfg_reg   <= CHR_CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_PRG_IDX))
                prg_cfg_reg <= cfg_data;
            if (cfg_valid && (cfg_index == CFG_CHR_IDX))
                chr_cfg_reg <= cfg_data[5:0];
            if (push.push)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            out_data_reg <= {2'b00, push.mir, push.ram, push.page, push.slot};
            out_kind_reg <= push.kind;
            out_last_reg <= push.last;
        end
    end

    sbm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .req_type    (s_axis_tuser),
        .bus_address (s_axis_tdata[15:0]),
        .bus_data    (s_axis_tdata[23:16]),
        .prg_banks   (prg_cfg_reg),
        .chr_banks   (chr_cfg_reg),
        .out_free    (out_free),
        .push        (push),
        .rem_req     (rem_req),
        .rem_rsp     (rem_rsp)
    );

    sbm_rem_unit u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ----- rtl/sbm_rem_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_rem_unit
// shared restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module sbm_rem_unit
    import sbm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rem_req_t req,
    output rem_rsp_t rsp
);

    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic [8:0] div_reg;
    logic [8:0] div_next;
    logic [6:0] dvd_reg;
    logic [6:0] dvd_next;
    logic [6:0] rem_reg;
    logic [6:0] rem_next;
    logic [6:0] trial;

    assign trial = {rem_reg[5:0], dvd_reg[6]};

    always_comb
    begin
        cnt_next = cnt_reg;
        div_next = div_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        if (req.start)
        begin
            cnt_next = DIV_STEPS;
            div_next = req.divisor;
            dvd_next = req.dividend;
            rem_next = 7'd0;
        end
        else if (cnt_reg != 3'd0)
        begin
            cnt_next = cnt_reg - 3'd1;
            dvd_next = {dvd_reg[5:0], 1'b0};
            if ({2'b00, trial} >= div_reg)
                rem_next = trial - div_reg[6:0];
            else
                rem_next = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy      = (cnt_reg != 3'd0);
    assign rsp.remainder = (div_reg == 9'd0) ? 7'd0 : rem_reg;

endmodule
`default_nettype wire

// ----- rtl/sbm_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_seq
// serial shifter, mapper state and result sequencer
// ----------------------------------------------------------------------------
module sbm_seq
    import sbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [15:0] bus_address,
    input  logic [7:0] bus_data,
    input  logic [6:0] prg_banks,
    input  logic [5:0] chr_banks,
    input  logic       out_free,
    output out_push_t  push,
    output rem_req_t   rem_req,
    input  rem_rsp_t   rem_rsp
);

    state_t state_reg;
    state_t state_next;
    phase_t phase_reg;
    phase_t phase_next;

    logic [2:0]      shift_count_reg;
    logic [2:0]      shift_count_next;
    logic [4:0]      shift_value_reg;
    logic [4:0]      shift_value_next;
    logic [3:0][4:0] map_reg;
    logic [3:0][4:0] map_next;
    logic [1:0]      outer_base_reg;
    logic [1:0]      outer_base_next;
    logic            swap_pending_reg;
    logic            swap_pending_next;
    logic [3:0][6:0] prg_bank_reg;
    logic [3:0][6:0] prg_bank_next;

    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       chr_pend_reg;
    logic       chr_pend_next;
    logic       chr_ram_reg;
    logic       chr_ram_next;
    logic [2:0] chr_first_reg;
    logic [2:0] chr_first_next;
    logic [2:0] chr_last_reg;
    logic [2:0] chr_last_next;
    logic [6:0] chr_base_reg;
    logic [6:0] chr_base_next;
    logic [1:0] mir_reg;
    logic [1:0] mir_next;

    logic       accept;
    logic       do_mir;
    logic       do_prg;
    logic       do_chr;
    logic       large_1024;
    logic       large_512;
    logic       size_small;
    logic       chr_none;
    logic [6:0] hp0;
    logic [6:0] hp1;
    logic [6:0] chr_page;
    logic       emit_last;
    logic       no_div;

    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign large_1024 = (prg_banks == PRG_1024K);
    assign large_512  = (prg_banks == PRG_512K);
    assign size_small = !large_1024 && !large_512;
    assign chr_none   = (chr_banks == 6'd0);
    assign hp0        = size_small ? ({prg_banks[5:0], 1'b0} - 7'd2) : LARGE_HI0;
    assign hp1        = size_small ? ({prg_banks[5:0], 1'b0} - 7'd1) : LARGE_HI1;
    assign chr_page   = chr_base_reg + {4'b0000, idx_reg};
    assign no_div     = (phase_reg == PH_MIR) || ((phase_reg == PH_CHR) && chr_ram_reg);

    // mapper state update on an accepted item
    always_comb
    begin
        logic [4:0] sv;
        logic [2:0] cnt1;
        logic [1:0] r;
        logic [4:0] c0;
        logic [4:0] r1;
        logic [4:0] r2;
        logic [6:0] b;
        shift_count_next  = shift_count_reg;
        shift_value_next  = shift_value_reg;
        map_next          = map_reg;
        outer_base_next   = outer_base_reg;
        swap_pending_next = swap_pending_reg;
        prg_bank_next     = prg_bank_reg;
        do_mir            = 1'b0;
        do_prg            = 1'b0;
        do_chr            = 1'b0;
        chr_ram_next      = chr_ram_reg;
        chr_first_next    = chr_first_reg;
        chr_last_next     = chr_last_reg;
        chr_base_next     = chr_base_reg;
        mir_next          = mir_reg;
        sv   = shift_value_reg | ({4'b0000, bus_data[0]} << shift_count_reg);
        cnt1 = shift_count_reg + 3'd1;
        r    = bus_address[14:13];
        c0   = (r == REG_CTRL) ? sv : map_reg[REG_CTRL];
        r1   = (r == REG_CHR0) ? sv : map_reg[REG_CHR0];
        r2   = (r == REG_CHR1) ? sv : map_reg[REG_CHR1];
        b    = {1'b0, sv, 1'b0};
        if (accept)
        begin
            unique case (req_type)
                REQ_WRITE:
                begin
                    if (bus_data[7])
                    begin
                        shift_count_next = 3'd0;
                        shift_value_next = 5'd0;
                    end
                    else if (cnt1 < SHIFT_BITS)
                    begin
                        shift_count_next = cnt1;
                        shift_value_next = sv;
                    end
                    else
                    begin
                        shift_count_next = 3'd0;
                        shift_value_next = 5'd0;
                        map_next[r]      = sv;
                        unique case (r)
                            REG_CTRL:
                            begin
                                do_mir   = 1'b1;
                                mir_next = ~c0[1:0];
                            end
                            REG_CHR0:
                            begin
                                if (large_1024)
                                begin
                                    if (c0[4])
                                    begin
                                        if (swap_pending_reg)
                                        begin
                                            outer_base_next   = {c0[3] & r2[4], r1[4]};
                                            do_prg            = 1'b1;
                                            swap_pending_next = 1'b0;
                                        end
                                        else
                                            swap_pending_next = 1'b1;
                                    end
                                    else
                                    begin
                                        outer_base_next = {r1[4], r1[4]};
                                        do_prg          = 1'b1;
                                    end
                                end
                                else if (large_512 && chr_none)
                                begin
                                    outer_base_next = {1'b0, r1[4]};
                                    do_prg          = 1'b1;
                                end
                                else if (!chr_none)
                                begin
                                    do_chr         = 1'b1;
                                    chr_ram_next   = 1'b0;
                                    chr_first_next = 3'd0;
                                    if (c0[4])
                                    begin
                                        chr_last_next = 3'd3;
                                        chr_base_next = {sv, 2'b00};
                                    end
                                    else
                                    begin
                                        chr_last_next = 3'd7;
                                        chr_base_next = {sv[4:1], 3'b000};
                                    end
                                end
                            end
                            REG_CHR1:
                            begin
                                if (large_1024 && c0[3])
                                begin
                                    if (swap_pending_reg)
                                    begin
                                        outer_base_next   = {r2[4], r1[4]};
                                        do_prg            = 1'b1;
                                        swap_pending_next = 1'b0;
                                    end
                                    else
                                        swap_pending_next = 1'b1;
                                end
                                if (c0[4])
                                begin
                                    do_chr         = 1'b1;
                                    chr_ram_next   = chr_none;
                                    chr_first_next = 3'd4;
                                    chr_last_next  = 3'd3;
                                    chr_base_next  = {sv, 2'b00};
                                end
                            end
                            REG_PRG:
                            begin
                                do_prg = 1'b1;
                                if (c0[3])
                                begin
                                    if (c0[2])
                                    begin
                                        prg_bank_next[0] = b;
                                        prg_bank_next[1] = b + 7'd1;
                                        prg_bank_next[2] = hp0;
                                        prg_bank_next[3] = hp1;
                                    end
                                    else if (size_small)
                                    begin
                                        prg_bank_next[0] = 7'd0;
                                        prg_bank_next[1] = 7'd1;
                                        prg_bank_next[2] = b;
                                        prg_bank_next[3] = b + 7'd1;
                                    end
                                end
                                else
                                begin
                                    prg_bank_next[0] = b;
                                    prg_bank_next[1] = b + 7'd1;
                                    if (size_small)
                                    begin
                                        prg_bank_next[2] = b + 7'd2;
                                        prg_bank_next[3] = b + 7'd3;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                REQ_INIT:
                begin
                    shift_count_next    = 3'd0;
                    shift_value_next    = 5'd0;
                    map_next            = '0;
                    map_next[REG_CTRL]  = CTRL_RESET;
                    outer_base_next     = 2'd0;
                    swap_pending_next   = 1'b0;
                    prg_bank_next[0]    = 7'd0;
                    prg_bank_next[1]    = 7'd1;
                    prg_bank_next[2]    = hp0;
                    prg_bank_next[3]    = hp1;
                    do_prg              = 1'b1;
                end
                REQ_RESTORE:
                begin
                    do_prg = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign emit_last = (phase_reg == PH_MIR)
                    || ((phase_reg == PH_PRG) && (idx_reg[1:0] == 2'd3) && !chr_pend_reg)
                    || ((phase_reg == PH_CHR) && (idx_reg == chr_last_reg));

    // next state
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        chr_pend_next = chr_pend_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (do_mir || do_prg || do_chr))
                begin
                    state_next    = ST_START;
                    idx_next      = 3'd0;
                    chr_pend_next = do_chr;
                    if (do_mir)
                        phase_next = PH_MIR;
                    else if (do_prg)
                        phase_next = PH_PRG;
                    else
                        phase_next = PH_CHR;
                end
            end
            ST_START:
            begin
                state_next = no_div ? ST_EMIT : ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!rem_rsp.busy)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (emit_last)
                        state_next = ST_IDLE;
                    else if ((phase_reg == PH_PRG) && (idx_reg[1:0] == 2'd3))
                    begin
                        state_next = ST_START;
                        phase_next = PH_CHR;
                        idx_next   = 3'd0;
                    end
                    else
                    begin
                        state_next = ST_START;
                        idx_next   = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready         = (state_reg == ST_IDLE);
        rem_req.start    = 1'b0;
        rem_req.dividend = {outer_base_reg, prg_bank_reg[idx_reg[1:0]][4:0]};
        rem_req.divisor  = {1'b0, prg_banks, 1'b0};
        push             = '0;
        if (phase_reg == PH_CHR)
        begin
            rem_req.dividend = chr_page;
            rem_req.divisor  = {chr_banks, 3'b000};
        end
        if ((state_reg == ST_START) && !no_div)
            rem_req.start = 1'b1;
        if ((state_reg == ST_EMIT) && out_free)
        begin
            push.push = 1'b1;
            push.last = emit_last;
            unique case (phase_reg)
                PH_MIR:
                begin
                    push.kind = KIND_MIR;
                    push.mir  = mir_reg;
                end
                PH_PRG:
                begin
                    push.kind = KIND_PRG;
                    push.slot = {1'b0, idx_reg[1:0]};
                    push.page = {1'b0, rem_rsp.remainder};
                end
                PH_CHR:
                begin
                    push.kind = KIND_CHR;
                    push.slot = chr_first_reg + idx_reg;
                    push.ram  = chr_ram_reg;
                    push.page = {1'b0, chr_ram_reg ? chr_page : rem_rsp.remainder};
                end
                default:
                begin
                    push.kind = KIND_MIR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_PRG;
            idx_reg          <= 3'd0;
            chr_pend_reg     <= 1'b0;
            shift_count_reg  <= 3'd0;
            shift_value_reg  <= 5'd0;
            map_reg          <= {5'd0, 5'd0, 5'd0, CTRL_RESET};
            outer_base_reg   <= 2'd0;
            swap_pending_reg <= 1'b0;
            prg_bank_reg     <= {7'd3, 7'd2, 7'd1, 7'd0};
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            idx_reg          <= idx_next;
            chr_pend_reg     <= chr_pend_next;
            shift_count_reg  <= shift_count_next;
            shift_value_reg  <= shift_value_next;
            map_reg          <= map_next;
            outer_base_reg   <= outer_base_next;
            swap_pending_reg <= swap_pending_next;
            prg_bank_reg     <= prg_bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chr_ram_reg   <= chr_ram_next;
        chr_first_reg <= chr_first_next;
        chr_last_reg  <= chr_last_next;
        chr_base_reg  <= chr_base_next;
        mir_reg       <= mir_next;
    end

endmodule
`default_nettype wire

// ----- rtl/sbm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_checker
// port-level checks of the serial bank mapper
// ----------------------------------------------------------------------------
module sbm_checker
    import sbm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [6:0]  cfg_data
);

    // stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled output item changed");

    // unknown request is dropped at once
    a_unknown_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == 2'd3) |=> s_axis_tready)
        else $error("unknown request kept the block busy");

    // mirroring item is alone and carries only the mode
    a_mir_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_MIR)
            |-> m_axis_tlast && (m_axis_tdata[11:0] == 12'd0))
        else $error("bad mirroring item");

    // program items address slots 0..3 and carry no ram or mode bits
    a_prg_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_PRG)
            |-> (m_axis_tdata[2] == 1'b0) && (m_axis_tdata[15:11] == 5'd0))
        else $error("bad program item");

    // no item kind beyond the three defined
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("undefined item kind");

endmodule

bind serial_bank_mapper_unit sbm_checker u_sbm_checker (.*);
`default_nettype wire
